// File: src/uxde_pkg.sv
// Shared constants and types for the XOR difference patch encoder.
`default_nettype none

package uxde_pkg;

  // Default width of the matching-byte counter
  localparam int CountBitsDef = 32;

  // Bijective base-128 digits of the match count
  localparam int DigitBits = 7;
  localparam logic [7:0] FinalDigitFlag = 8'h80;
  localparam logic [7:0] ZeroByte = 8'h00;

  // Position counter
  localparam int PosBits = 32;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  // One digit step from the shared digit unit
  typedef struct packed {
    logic                 last;   // no further digits after this one
    logic [DigitBits-1:0] digit;  // low seven bits of the current value
  } digit_t;

endpackage

`default_nettype wire

// File: src/ups_xor_diff_encoder.sv
// Top level of the XOR difference patch encoder: sequencer and output register.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/tready         tdata {modified, original}, tlast final_byte
//  m_axis   out  m_axis_tvalid/tready         tdata patch_byte, tlast run_last,
//                                             tuser patch_end
//  cfg      in   cfg_valid/cfg_ready          cfg_data source_length
//
//  A matching byte outside a block is only counted. An item inside a block is
//  accepted, then its XOR byte is sent. A block-opening item is accepted, then its
//  count digits go one per cycle through the shared digit unit, then its XOR byte;
//  a final item that leaves a block open adds a trailing zero. Output stalls hold
//  the sequencer. Reset clears the control state; no clearing pass is needed.
`default_nettype none

module ups_xor_diff_encoder
  import uxde_pkg::*;
#(
  parameter int CountBits = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] original_byte, [15:8] modified_byte
  input  wire logic        s_axis_tlast_i,   // final_byte
  // result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,   // [7:0] patch_byte
  output logic             m_axis_tlast_o,   // run_last
  output logic             m_axis_tuser_o,   // [0] patch_end
  // source length register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCount = 2'd1;
  localparam logic [1:0] StXor   = 2'd2;
  localparam logic [1:0] StZero  = 2'd3;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [1:0]           state_q, state_d;
  logic                 in_block_q, in_block_d;
  logic [CountBits-1:0] match_count_q, match_count_d;
  logic [PosBits-1:0]   position_q, position_d;
  logic [31:0]          src_len_q;
  logic [CountBits-1:0] work_q, work_d;
  logic [7:0]           xor_q, xor_d;
  logic                 fin_q, fin_d;
  logic                 trail_q, trail_d;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 out_end_q, out_end_d;

  logic                 emit_ok;
  logic                 in_fire;
  logic [7:0]           orig_byte;
  logic [7:0]           x_byte;
  digit_t               dstep;
  logic [CountBits-1:0] dnext;

  uxde_digit_unit #(
    .CountBits(CountBits)
  ) u_digit (
    .value_i(work_q),
    .step_o (dstep),
    .next_o (dnext)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_ok         = !out_valid_q || m_axis_tready_i;

  // Original bytes past the source end read as zero
  assign orig_byte = (position_q < src_len_q) ? s_axis_tdata_i[7:0] : ZeroByte;
  assign x_byte    = orig_byte ^ s_axis_tdata_i[15:8];

  // Sequencer
  always_comb begin
    state_d       = state_q;
    in_block_d    = in_block_q;
    match_count_d = match_count_q;
    position_d    = position_q;
    work_d        = work_q;
    xor_d         = xor_q;
    fin_d         = fin_q;
    trail_d       = trail_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    out_end_d     = out_end_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          xor_d      = x_byte;
          fin_d      = s_axis_tlast_i;
          position_d = (position_q != PosMax) ? position_q + PosBits'(1) : position_q;
          if (!in_block_q) begin
            if (x_byte == ZeroByte) begin
              if (match_count_q != CountMax) begin
                match_count_d = match_count_q + CountBits'(1);
              end
            end else begin
              work_d        = match_count_q;
              match_count_d = '0;
              in_block_d    = 1'b1;
              state_d       = StCount;
            end
          end else begin
            state_d = StXor;
            if (x_byte == ZeroByte) begin
              in_block_d    = 1'b0;
              match_count_d = '0;
            end
          end
          // end of stream: trailing zero if the block stays open, then restart
          trail_d = s_axis_tlast_i && in_block_d;
          if (s_axis_tlast_i) begin
            in_block_d    = 1'b0;
            match_count_d = '0;
            position_d    = '0;
          end
        end
      end
      StCount: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_byte_d  = {dstep.last, dstep.digit};
          out_last_d  = 1'b0;
          out_end_d   = 1'b0;
          work_d      = dnext;
          if (dstep.last) begin
            state_d = StXor;
          end
        end
      end
      StXor: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_byte_d  = xor_q;
          out_last_d  = !trail_q;
          out_end_d   = fin_q && !trail_q;
          state_d     = trail_q ? StZero : StIdle;
        end
      end
      StZero: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_byte_d  = ZeroByte;
          out_last_d  = 1'b1;
          out_end_d   = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      in_block_q    <= 1'b0;
      match_count_q <= '0;
      position_q    <= '0;
      src_len_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      in_block_q    <= in_block_d;
      match_count_q <= match_count_d;
      position_q    <= position_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        src_len_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    xor_q      <= xor_d;
    fin_q      <= fin_d;
    trail_q    <= trail_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_end_q;

`ifndef SYNTHESIS
  // the match count is always clear while a block is open
  a_block_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_block_q |-> (match_count_q == '0))
    else $error("match count not clear inside block");

  // stream end always closes an item's results
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("patch end without run last");

  // a final item restarts the position and closes the block
  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast_i) |=> (position_q == '0 && !in_block_q))
    else $error("state not restarted after final item");

  // trailing zero only follows a final item, with the block already closed
  a_zero_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StZero) |-> (fin_q && !in_block_q))
    else $error("trailing zero outside stream end");
`endif

endmodule

`default_nettype wire

// File: src/uxde_digit_unit.sv
// Shared digit unit: peels one base-128 digit off the match count per cycle while the output is not stalled.
`default_nettype none

module uxde_digit_unit
  import uxde_pkg::*;
#(
  parameter int CountBits = CountBitsDef
) (
  input  wire logic [CountBits-1:0] value_i,
  output digit_t                    step_o,
  output logic      [CountBits-1:0] next_o
);

  logic [CountBits-1:0] shifted;

  // Shift out the low digit; the bijective form takes one off the rest
  assign shifted       = value_i >> DigitBits;
  assign step_o.digit  = value_i[DigitBits-1:0];
  assign step_o.last   = (shifted == '0);
  assign next_o        = shifted - CountBits'(1);

endmodule

`default_nettype wire

// File: verif/ups_xor_diff_encoder_tb.sv
// Self-checking testbench for the XOR difference patch encoder.
`timescale 1ns / 100ps

module ups_xor_diff_encoder_tb
  import uxde_pkg::*;
();

  localparam int DrainCycles = 16;    // longest item: accept, 5 digits, XOR byte, trailing zero
  localparam int StallLimit  = 4000;  // cycles with no item moving on any channel
  localparam int PhaseItems  = 20;
  localparam int NumRows     = 22;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One directed row: an input item or a source length write
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  orig;
    logic [7:0]  modb;
    logic        fin;
    logic        typed;  // expected bytes given below
    logic [1:0]  tn;
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [7:0]  t2;
    logic [31:0] cfg;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       rlast;
    logic       pend;
  } patch_res_t;

  // Directed items; the source length is zero after reset
  localparam dir_row_t DirTab [NumRows] = '{
    '{ROW_ITEM, 8'hFF, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h55, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'hFF, 1'b0, 1'b1, 2'd2, 8'h82, 8'hFF, 8'h00, 32'h0},
    '{ROW_ITEM, 8'hAA, 8'h80, 1'b0, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h12, 8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'h01, 1'b1, 1'b1, 2'd3, 8'h80, 8'h01, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'h00, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_CFG,  8'h00, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF},
    '{ROW_ITEM, 8'hFF, 8'hFF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'hFF, 1'b0, 1'b1, 2'd2, 8'h81, 8'hFF, 8'h00, 32'h0},
    '{ROW_ITEM, 8'hFF, 8'h00, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h3C, 8'h3C, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h81, 8'h7E, 1'b1, 1'b1, 2'd3, 8'h80, 8'hFF, 8'h00, 32'h0},
    '{ROW_CFG,  8'h00, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'd2},
    '{ROW_ITEM, 8'h11, 8'h11, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h22, 8'h22, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h33, 8'h33, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h44, 8'h00, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h5A, 8'hA5, 1'b1, 1'b1, 2'd3, 8'h80, 8'hFF, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'h01, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'h00, 8'h02, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_ITEM, 8'hF0, 8'h0F, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 32'h0}
  };

  // Per phase: sender idle and receiver stall, percent of cycles
  localparam int IdlePct  [4] = '{0, 65, 0, 35};
  localparam int StallPct [4] = '{0, 0, 65, 35};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  // Encoder state as predicted
  logic [31:0]              src_len = '0;
  logic                     blk_open = 1'b0;
  logic [CountBitsDef-1:0]  match_cnt = '0;
  logic [PosBits-1:0]       byte_pos = '0;

  patch_res_t patch_q [$];
  patch_res_t step_res [$];
  patch_res_t exp_res;
  int idle_pct = 0;
  int stall_pct = 0;
  int n_fail = 0;
  int n_sent = 0;
  int idle_cycles = 0;

  ups_xor_diff_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Append one patch byte to the results of the current item
  task automatic add_step(input patch_res_t r);
    step_res.insert(step_res.size(), r);
  endtask

  // Append one patch byte to the expected stream
  task automatic add_expect(input patch_res_t r);
    patch_q.insert(patch_q.size(), r);
  endtask

  // Encode one item into step_res and advance the predicted state
  task automatic xor_encode_step(input logic [7:0] orig, input logic [7:0] modb,
                                 input logic fin);
    logic [7:0] eff;
    logic [7:0] x;
    logic [CountBitsDef-1:0] v;
    patch_res_t r;
    step_res.delete();
    eff = (byte_pos < src_len) ? orig : ZeroByte;
    x = eff ^ modb;
    r = '0;
    if (!blk_open) begin
      if (x == ZeroByte) begin
        if (match_cnt != '1) match_cnt = match_cnt + 1'b1;
      end else begin
        // bijective base-128 count, low digit first
        v = match_cnt;
        forever begin
          r.pbyte = {1'b0, v[DigitBits-1:0]};
          v = v >> DigitBits;
          if (v == '0) begin
            r.pbyte = r.pbyte | FinalDigitFlag;
            add_step(r);
            break;
          end
          v = v - 1'b1;
          add_step(r);
        end
        r.pbyte = x;
        add_step(r);
        blk_open = 1'b1;
        match_cnt = '0;
      end
    end else begin
      r.pbyte = x;
      add_step(r);
      if (x == ZeroByte) begin
        blk_open = 1'b0;
        match_cnt = '0;
      end
    end
    if (byte_pos != PosMax) byte_pos = byte_pos + 1'b1;
    if (fin) begin
      // open block gets a trailing zero
      if (blk_open) begin
        r.pbyte = ZeroByte;
        add_step(r);
      end
      if (step_res.size() > 0) step_res[step_res.size()-1].pend = 1'b1;
      blk_open = 1'b0;
      match_cnt = '0;
      byte_pos = '0;
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].rlast = 1'b1;
  endtask

  // Offer one item, wait for it to be taken, then queue its patch bytes
  task automatic send_item(input logic [7:0] orig, input logic [7:0] modb, input logic fin,
                           input logic typed, input int tn, input logic [7:0] t0,
                           input logic [7:0] t1, input logic [7:0] t2);
    patch_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {modb, orig};
    s_axis_tlast_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    xor_encode_step(orig, modb, fin);
    n_sent++;
    if (typed) begin
      for (int k = 0; k < tn; k++) begin
        r.pbyte = (k == 0) ? t0 : (k == 1) ? t1 : t2;
        r.rlast = (k == tn - 1);
        r.pend  = r.rlast && fin;
        add_expect(r);
      end
    end else begin
      foreach (step_res[k]) add_expect(step_res[k]);
    end
  endtask

  // Hold the input side until every queued patch byte has left the block
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (patch_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_source_length(input logic [31:0] len);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    src_len = len;
    cfg_valid_i <= 1'b0;
  endtask

  // One stream: lead matching bytes, then a difference if lead is nonzero, then a random tail.
  // The last item carries final_byte; pause_at drains the encoder before the item at that index.
  task automatic run_stream(input int lead, input int tail, input int match_pct,
                            input int pause_at);
    logic [7:0] orig;
    logic [7:0] eff;
    logic [7:0] modb;
    int unsigned pos;
    int total;
    pos = 0;
    total = lead + tail;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) drain_results();
      orig = 8'($urandom);
      eff = (pos < src_len) ? orig : ZeroByte;
      if (i < lead)
        modb = eff;
      else if (i == lead && lead > 0)
        modb = eff ^ 8'($urandom_range(1, 255));
      else if ($urandom_range(99) < 10)
        modb = 8'($urandom);
      else if ($urandom_range(99) < match_pct)
        modb = eff;
      else
        modb = eff ^ 8'($urandom_range(1, 255));
      send_item(orig, modb, i == total - 1, 1'b0, 0, '0, '0, '0);
      pos++;
    end
  endtask

  // Receiver readiness
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each patch byte with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (patch_q.size() == 0) begin
        $error("unexpected patch item: patch_byte %h", m_axis_tdata_o);
        n_fail++;
      end else begin
        exp_res = patch_q.pop_front();
        if (m_axis_tdata_o !== exp_res.pbyte) begin
          $error("patch_byte: expected %h, got %h", exp_res.pbyte, m_axis_tdata_o);
          n_fail++;
        end
        if (m_axis_tlast_o !== exp_res.rlast) begin
          $error("run_last: expected %b, got %b", exp_res.rlast, m_axis_tlast_o);
          n_fail++;
        end
        if (m_axis_tuser_o !== exp_res.pend) begin
          $error("patch_end: expected %b, got %b", exp_res.pend, m_axis_tuser_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles where no channel moves an item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[ups_xor_diff_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    int start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items
    foreach (DirTab[i]) begin
      if (DirTab[i].kind == ROW_CFG)
        write_source_length(DirTab[i].cfg);
      else
        send_item(DirTab[i].orig, DirTab[i].modb, DirTab[i].fin, DirTab[i].typed,
                  int'(DirTab[i].tn), DirTab[i].t0, DirTab[i].t1, DirTab[i].t2);
    end

    // Random streams under four idling patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_source_length(32'hFFFF_FFFF);
        1: write_source_length(32'($urandom_range(1, 8)));
        2: write_source_length(32'h0);
        default: write_source_length(32'($urandom));
      endcase
      idle_pct  = IdlePct[p];
      stall_pct = StallPct[p];
      start = n_sent;
      // pause after a block has been opened
      if (p == 1) run_stream(3, 6, 30, 5);
      while (n_sent - start < PhaseItems)
        run_stream($urandom_range(0, 4), $urandom_range(1, 8), $urandom_range(20, 70), -1);
    end

    drain_results();
    if (patch_q.size() != 0) begin
      $error("patch bytes never produced: %0d", patch_q.size());
      n_fail++;
    end
    if (n_fail == 0)
      $display("[ups_xor_diff_encoder] OK");
    else
      $display("[ups_xor_diff_encoder] ERROR");
    $finish;
  end

endmodule

// File: files.f
src/uxde_pkg.sv
src/uxde_digit_unit.sv
src/ups_xor_diff_encoder.sv
verif/ups_xor_diff_encoder_tb.sv
